### rtl/core/sdaa_pkg.sv
// Shared constants, types and helpers for the stick direction arbiter core.
package sdaa_pkg;

    localparam int PORTS       = 4;
    localparam int SAMPLE_BITS = 8;
    localparam int PORT_W      = (PORTS > 1) ? $clog2(PORTS) : 1;

    localparam int STICK_W  = 32;
    localparam int MASK_W   = 4;
    localparam int TIME_W   = 32;
    localparam int DIR_W    = 3;
    localparam int AXES_W   = 2;
    localparam int ENGAGE_W = 8;
    localparam int REL_W    = 7;

    localparam int LANE_BITS   = PORTS * SAMPLE_BITS;
    localparam int STICK_PAD_W = (LANE_BITS > STICK_W) ? LANE_BITS : STICK_W;
    localparam int MASK_PAD_W  = (PORTS > MASK_W) ? PORTS : MASK_W;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AXES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENGAGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAXEL   = 3'd6;

    localparam logic [AXES_W-1:0]   AXES_RST    = 2'd3;
    localparam logic                REPEAT_RST  = 1'b0;
    localparam logic [ENGAGE_W-1:0] ENGAGE_RST  = 8'd64;
    localparam logic [REL_W-1:0]    RELEASE_RST = 7'd32;
    localparam logic [TIME_W-1:0]   INITIAL_RST = 32'd400000;
    localparam logic [TIME_W-1:0]   PERIOD_RST  = 32'd100000;
    localparam logic [TIME_W-1:0]   MAXEL_RST   = 32'd100000;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    // What one lane finds about its port's sample.
    typedef struct packed {
        logic                   valid;
        logic                   neutral;   // valid and every allowed axis at rest
        logic [DIR_W-1:0]       cand;
        logic [SAMPLE_BITS-1:0] mag;       // larger of the allowed axis magnitudes
        logic                   weak_l;    // strength toward each direction <= release
        logic                   weak_r;
        logic                   weak_u;
        logic                   weak_d;
    } lane_t;

    function automatic logic opposite(input logic [DIR_W-1:0] a,
                                      input logic [DIR_W-1:0] b);
        return (a == DIR_LEFT  && b == DIR_RIGHT) || (a == DIR_RIGHT && b == DIR_LEFT) ||
               (a == DIR_UP    && b == DIR_DOWN)  || (a == DIR_DOWN  && b == DIR_UP);
    endfunction

    function automatic logic weak_of(input lane_t l, input logic [DIR_W-1:0] d);
        logic w;
        case (d)
            DIR_LEFT:  w = l.weak_l;
            DIR_RIGHT: w = l.weak_r;
            DIR_UP:    w = l.weak_u;
            DIR_DOWN:  w = l.weak_d;
            default:   w = 1'b1;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/sdaa_lane.sv
// Per-port lane: magnitudes, neutral test, candidate direction and release strengths.
module sdaa_lane (
    input  logic                                      valid,
    input  logic signed [sdaa_pkg::SAMPLE_BITS-1:0]   sample_x,
    input  logic signed [sdaa_pkg::SAMPLE_BITS-1:0]   sample_y,
    input  logic [sdaa_pkg::AXES_W-1:0]               allowed_axes,
    input  logic [sdaa_pkg::ENGAGE_W-1:0]             engage,
    input  logic [sdaa_pkg::REL_W-1:0]                release_thr,
    output sdaa_pkg::lane_t                           lane
);

    localparam int SB = sdaa_pkg::SAMPLE_BITS;

    logic [SB:0]   neg_x, neg_y;
    logic [SB-1:0] mag_x, mag_y, ax, ay, eng, rel;
    logic          x_neg, y_neg, x_pos, y_pos;
    logic          x_rest, y_rest;

    always_comb begin
        x_neg = sample_x[SB-1];
        y_neg = sample_y[SB-1];
        x_pos = !x_neg && (sample_x != '0);
        y_pos = !y_neg && (sample_y != '0);
        neg_x = -{sample_x[SB-1], sample_x};
        neg_y = -{sample_y[SB-1], sample_y};
        // full-scale negative magnitude still fits SB bits unsigned
        mag_x = x_neg ? neg_x[SB-1:0] : sample_x;
        mag_y = y_neg ? neg_y[SB-1:0] : sample_y;
        ax    = allowed_axes[0] ? mag_x : '0;
        ay    = allowed_axes[1] ? mag_y : '0;
        eng   = SB'(engage);
        rel   = SB'(release_thr);

        x_rest = !allowed_axes[0] || (mag_x <= rel);
        y_rest = !allowed_axes[1] || (mag_y <= rel);

        lane.valid   = valid;
        lane.neutral = valid && x_rest && y_rest;
        lane.mag     = (ax > ay) ? ax : ay;
        if (ax < eng && ay < eng) begin
            lane.cand = sdaa_pkg::DIR_NONE;
        end else if (ax >= ay) begin
            lane.cand = x_neg ? sdaa_pkg::DIR_LEFT : sdaa_pkg::DIR_RIGHT;
        end else begin
            lane.cand = y_neg ? sdaa_pkg::DIR_DOWN : sdaa_pkg::DIR_UP;
        end
        // strengths use the raw samples, not the axis mask
        lane.weak_l = !x_neg || (mag_x <= rel);
        lane.weak_r = !x_pos || (mag_x <= rel);
        lane.weak_u = !y_pos || (mag_y <= rel);
        lane.weak_d = !y_neg || (mag_y <= rel);
    end

endmodule

### rtl/core/sdaa_merge.sv
// Merge stage: strongest armed engaged port, lowest index on a tie.
module sdaa_merge (
    input  sdaa_pkg::lane_t                          lanes [sdaa_pkg::PORTS],
    input  logic [sdaa_pkg::PORTS-1:0]               armed,
    input  logic [sdaa_pkg::ENGAGE_W-1:0]            engage,
    output logic                                     found,
    output logic [sdaa_pkg::PORT_W-1:0]              port
);

    logic [sdaa_pkg::SAMPLE_BITS-1:0] best;
    logic [sdaa_pkg::SAMPLE_BITS-1:0] eng;

    always_comb begin
        eng   = sdaa_pkg::SAMPLE_BITS'(engage);
        found = 1'b0;
        port  = '0;
        best  = '0;
        for (int i = 0; i < sdaa_pkg::PORTS; i++) begin
            if (lanes[i].valid && armed[i] && lanes[i].mag >= eng &&
                (!found || lanes[i].mag > best)) begin
                found = 1'b1;
                port  = sdaa_pkg::PORT_W'(i);
                best  = lanes[i].mag;
            end
        end
    end

endmodule

### rtl/core/stick_direction_arbiter_autorepeat_core.sv
// Top level: lane stage, merge and ownership/repeat state, output queue, APB registers.
//
//  Channel | Ports                                                | Beat
//  --------+------------------------------------------------------+---------------------------
//  s_      | s_valid/s_ready, port_valid_mask, stick_x/y, elapsed | one frame of stick samples
//  m_      | m_valid/m_ready, m_direction                         | one menu direction
//  apb     | psel/penable/pwrite/paddr/pwdata/prdata/pready       | one register access
//
// One frame per cycle while the output queue has room: lanes run in parallel into a stage
// register, and the merge plus state update (one saturating 32-bit add and compare) acts on it as it leaves.
// m_valid rises once a beat's result has passed the stage register into the output queue.
// Reset is synchronous and takes effect at once; no clearing pass.
// A two-entry output queue absorbs m_ready stalls; s_ready drops only when it is full
// and stage one holds a frame.
module stick_direction_arbiter_autorepeat_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sdaa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sdaa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sdaa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sdaa_pkg::MASK_W-1:0]         s_port_valid_mask,
    input  logic [sdaa_pkg::STICK_W-1:0]        s_stick_x_packed,
    input  logic [sdaa_pkg::STICK_W-1:0]        s_stick_y_packed,
    input  logic [sdaa_pkg::TIME_W-1:0]         s_elapsed_us,
    input  logic                                s_inhibited,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sdaa_pkg::DIR_W-1:0]          m_direction
);

    localparam int SB = sdaa_pkg::SAMPLE_BITS;
    localparam int NP = sdaa_pkg::PORTS;
    localparam int TW = sdaa_pkg::TIME_W;

    // configuration
    logic [sdaa_pkg::AXES_W-1:0]   axes_reg, axes_next;
    logic                          rep_en_reg, rep_en_next;
    logic [sdaa_pkg::ENGAGE_W-1:0] engage_reg, engage_next;
    logic [sdaa_pkg::REL_W-1:0]    release_reg, release_next;
    logic [TW-1:0]                 initial_reg, initial_next;
    logic [TW-1:0]                 period_reg, period_next;
    logic [TW-1:0]                 maxel_reg, maxel_next;

    logic                          cfg_wr;
    logic [sdaa_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic                          policy_change;

    // arbiter state
    logic                          owner_reg, owner_next;
    logic [sdaa_pkg::PORT_W-1:0]   owner_port_reg, owner_port_next;
    logic [sdaa_pkg::DIR_W-1:0]    held_dir_reg, held_dir_next;
    logic [TW-1:0]                 held_time_reg, held_time_next;
    logic                          started_reg, started_next;
    logic [NP-1:0]                 armed_reg, armed_next;

    // stage one
    logic [sdaa_pkg::STICK_PAD_W-1:0] x_pad, y_pad;
    logic [sdaa_pkg::MASK_PAD_W-1:0]  mask_pad;
    sdaa_pkg::lane_t               lane_c [NP];
    sdaa_pkg::lane_t               s1_lane_reg [NP];
    logic                          s1_valid_reg, s1_valid_next;
    logic [TW-1:0]                 s1_elapsed_reg;
    logic                          s1_inhib_reg;
    logic                          s_fire, s1_adv;

    // stage two
    logic                          found;
    logic [sdaa_pkg::PORT_W-1:0]   best_port;
    sdaa_pkg::lane_t               lane_op;
    sdaa_pkg::lane_t               lane_best;
    logic [NP-1:0]                 armed_pre, keep, neutral_v;
    logic [sdaa_pkg::DIR_W-1:0]    out_dir;
    logic [TW:0]                   sum;
    logic [TW-1:0]                 sat, deadline;
    logic [TW:0]                   diff;

    // output queue
    logic [1:0]                    q_count_reg, q_count_next;
    logic [sdaa_pkg::DIR_W-1:0]    q0_reg, q1_reg;
    logic                          q_space, pop;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[sdaa_pkg::CFG_ADDR_W-1:2];

    always_comb begin
        case (cfg_idx)
            sdaa_pkg::REG_AXES:    prdata = 32'(axes_reg);
            sdaa_pkg::REG_REPEAT:  prdata = 32'(rep_en_reg);
            sdaa_pkg::REG_ENGAGE:  prdata = 32'(engage_reg);
            sdaa_pkg::REG_RELEASE: prdata = 32'(release_reg);
            sdaa_pkg::REG_INITIAL: prdata = initial_reg;
            sdaa_pkg::REG_PERIOD:  prdata = period_reg;
            sdaa_pkg::REG_MAXEL:   prdata = maxel_reg;
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        axes_next     = axes_reg;
        rep_en_next   = rep_en_reg;
        engage_next   = engage_reg;
        release_next  = release_reg;
        initial_next  = initial_reg;
        period_next   = period_reg;
        maxel_next    = maxel_reg;
        policy_change = 1'b0;
        if (cfg_wr) begin
            case (cfg_idx)
                sdaa_pkg::REG_AXES: begin
                    axes_next     = pwdata[sdaa_pkg::AXES_W-1:0];
                    policy_change = (pwdata[sdaa_pkg::AXES_W-1:0] != axes_reg);
                end
                sdaa_pkg::REG_REPEAT: begin
                    rep_en_next   = pwdata[0];
                    policy_change = (pwdata[0] != rep_en_reg);
                end
                sdaa_pkg::REG_ENGAGE:  engage_next  = pwdata[sdaa_pkg::ENGAGE_W-1:0];
                sdaa_pkg::REG_RELEASE: release_next = pwdata[sdaa_pkg::REL_W-1:0];
                sdaa_pkg::REG_INITIAL: initial_next = pwdata;
                sdaa_pkg::REG_PERIOD:  period_next  = pwdata;
                sdaa_pkg::REG_MAXEL:   maxel_next   = pwdata;
                default: ;
            endcase
        end
    end

    // ---------------- stage one: lanes ----------------
    // samples past the packed field read as zero
    assign x_pad    = sdaa_pkg::STICK_PAD_W'(s_stick_x_packed);
    assign y_pad    = sdaa_pkg::STICK_PAD_W'(s_stick_y_packed);
    assign mask_pad = sdaa_pkg::MASK_PAD_W'(s_port_valid_mask);

    for (genvar g = 0; g < NP; g++) begin : g_lane
        sdaa_lane u_lane (
            .valid        (mask_pad[g]),
            .sample_x     (x_pad[g*SB +: SB]),
            .sample_y     (y_pad[g*SB +: SB]),
            .allowed_axes (axes_reg),
            .engage       (engage_reg),
            .release_thr  (release_reg),
            .lane         (lane_c[g])
        );
    end

    assign q_space = (q_count_reg != 2'd2);
    assign s1_adv  = s1_valid_reg && q_space;
    assign s_ready = !s1_valid_reg || q_space;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_lane_reg    <= lane_c;
            s1_elapsed_reg <= (s_elapsed_us > maxel_reg) ? maxel_reg : s_elapsed_us;
            s1_inhib_reg   <= s_inhibited;
        end
    end

    // ---------------- stage two: merge and state ----------------
    sdaa_merge u_merge (
        .lanes  (s1_lane_reg),
        .armed  (armed_pre),
        .engage (engage_reg),
        .found  (found),
        .port   (best_port)
    );

    assign lane_op   = s1_lane_reg[owner_port_reg];
    assign lane_best = s1_lane_reg[best_port];

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            neutral_v[i] = s1_lane_reg[i].neutral;
            armed_pre[i] = !s1_lane_reg[i].valid ? 1'b0 :
                           (s1_lane_reg[i].neutral ? 1'b1 : armed_reg[i]);
            keep[i]      = (sdaa_pkg::PORT_W'(i) == owner_port_reg) || s1_lane_reg[i].neutral;
        end
        sum      = {1'b0, held_time_reg} + {1'b0, s1_elapsed_reg};
        sat      = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
        deadline = started_reg ? period_reg : initial_reg;
        diff     = {1'b0, sat} - {1'b0, deadline};
    end

    always_comb begin
        owner_next      = owner_reg;
        owner_port_next = owner_port_reg;
        held_dir_next   = held_dir_reg;
        held_time_next  = held_time_reg;
        started_next    = started_reg;
        armed_next      = armed_reg;
        out_dir         = sdaa_pkg::DIR_NONE;

        if (s1_adv && axes_reg != '0) begin
            if (s1_inhib_reg) begin
                owner_next      = 1'b0;
                owner_port_next = '0;
                held_dir_next   = sdaa_pkg::DIR_NONE;
                held_time_next  = '0;
                started_next    = 1'b0;
                armed_next      = neutral_v;
            end else if (!owner_reg) begin
                armed_next = armed_pre;
                if (found) begin
                    owner_next      = 1'b1;
                    owner_port_next = best_port;
                    held_dir_next   = lane_best.cand;
                    held_time_next  = '0;
                    started_next    = 1'b0;
                    out_dir         = lane_best.cand;
                end
            end else begin
                armed_next = armed_pre & keep;
                if (!lane_op.valid) begin
                    owner_next      = 1'b0;
                    owner_port_next = '0;
                    held_dir_next   = sdaa_pkg::DIR_NONE;
                    held_time_next  = '0;
                    started_next    = 1'b0;
                end else if (!rep_en_reg) begin
                    if (lane_op.neutral) begin
                        owner_next      = 1'b0;
                        owner_port_next = '0;
                        held_dir_next   = sdaa_pkg::DIR_NONE;
                        held_time_next  = '0;
                        started_next    = 1'b0;
                    end
                end else if (lane_op.cand != sdaa_pkg::DIR_NONE &&
                             sdaa_pkg::opposite(held_dir_reg, lane_op.cand)) begin
                    // reversal restarts the hold
                    held_dir_next  = lane_op.cand;
                    held_time_next = '0;
                    started_next   = 1'b0;
                    out_dir        = lane_op.cand;
                end else if (sdaa_pkg::weak_of(lane_op, held_dir_reg)) begin
                    owner_next      = 1'b0;
                    owner_port_next = '0;
                    held_dir_next   = sdaa_pkg::DIR_NONE;
                    held_time_next  = '0;
                    started_next    = 1'b0;
                    // released on the held axis but still pushed sideways
                    if (!lane_op.neutral) begin
                        armed_next[owner_port_reg] = 1'b0;
                    end
                end else if (diff[TW]) begin
                    held_time_next = sat;
                end else begin
                    held_time_next = diff[TW-1:0];
                    started_next   = 1'b1;
                    out_dir        = held_dir_reg;
                end
            end
        end

        if (policy_change) begin
            owner_next      = 1'b0;
            owner_port_next = '0;
            held_dir_next   = sdaa_pkg::DIR_NONE;
            held_time_next  = '0;
            started_next    = 1'b0;
            armed_next      = '0;
        end
    end

    // ---------------- output queue ----------------
    assign m_valid     = (q_count_reg != 2'd0);
    assign m_direction = q0_reg;
    assign pop         = m_valid && m_ready;

    always_comb begin
        q_count_next = q_count_reg;
        case ({s1_adv, pop})
            2'b10:   q_count_next = q_count_reg + 2'd1;
            2'b01:   q_count_next = q_count_reg - 2'd1;
            default: q_count_next = q_count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && (q_count_reg == 2'd0 || (q_count_reg == 2'd1 && pop))) begin
            q0_reg <= out_dir;
        end else if (pop && q_count_reg == 2'd2) begin
            q0_reg <= q1_reg;
        end
        if (s1_adv && q_count_reg == 2'd1 && !pop) begin
            q1_reg <= out_dir;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axes_reg       <= sdaa_pkg::AXES_RST;
            rep_en_reg     <= sdaa_pkg::REPEAT_RST;
            engage_reg     <= sdaa_pkg::ENGAGE_RST;
            release_reg    <= sdaa_pkg::RELEASE_RST;
            initial_reg    <= sdaa_pkg::INITIAL_RST;
            period_reg     <= sdaa_pkg::PERIOD_RST;
            maxel_reg      <= sdaa_pkg::MAXEL_RST;
            owner_reg      <= 1'b0;
            owner_port_reg <= '0;
            held_dir_reg   <= sdaa_pkg::DIR_NONE;
            held_time_reg  <= '0;
            started_reg    <= 1'b0;
            armed_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            q_count_reg    <= 2'd0;
        end else begin
            axes_reg       <= axes_next;
            rep_en_reg     <= rep_en_next;
            engage_reg     <= engage_next;
            release_reg    <= release_next;
            initial_reg    <= initial_next;
            period_reg     <= period_next;
            maxel_reg      <= maxel_next;
            owner_reg      <= owner_next;
            owner_port_reg <= owner_port_next;
            held_dir_reg   <= held_dir_next;
            held_time_reg  <= held_time_next;
            started_reg    <= started_next;
            armed_reg      <= armed_next;
            s1_valid_reg   <= s1_valid_next;
            q_count_reg    <= q_count_next;
        end
    end

    // ---------------- assertions ----------------
    a_owner_has_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        owner_reg |-> (held_dir_reg != sdaa_pkg::DIR_NONE))
        else $error("owner held without a direction");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !owner_reg |-> (held_time_reg == '0 && !started_reg && owner_port_reg == '0))
        else $error("released owner left hold state behind");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count_reg == 2'd2) |-> !s1_adv)
        else $error("push into full output queue");

    a_beat_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && q_space && !(q_count_reg == 2'd1 && !pop)) |=> s1_valid_reg)
        else $error("accepted beat did not reach stage one");

endmodule
